FILE: rtl/core/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the shake and pickup detector.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int SPD_SLOTS       = 5;
	localparam int SPD_QUEUE_DEPTH = 4;
	localparam int SPD_QPTR_W      = $clog2(SPD_QUEUE_DEPTH);

	localparam int SPD_CFG_IDX_W   = 3;
	localparam int SPD_CFG_DATA_W  = 16;

	// register indexes of the configuration port
	localparam logic [SPD_CFG_IDX_W-1:0] CFG_REST_LEVEL   = 3'd0;
	localparam logic [SPD_CFG_IDX_W-1:0] CFG_SPIKE_MARGIN = 3'd1;
	localparam logic [SPD_CFG_IDX_W-1:0] CFG_WINDOW_MS    = 3'd2;
	localparam logic [SPD_CFG_IDX_W-1:0] CFG_COOLDOWN_MS  = 3'd3;
	localparam logic [SPD_CFG_IDX_W-1:0] CFG_SHAKE_COUNT  = 3'd4;

	localparam logic [14:0] RST_REST_LEVEL   = 15'd4096;
	localparam logic [14:0] RST_SPIKE_MARGIN = 15'd1672;
	localparam logic [15:0] RST_WINDOW_MS    = 16'd1000;
	localparam logic [15:0] RST_COOLDOWN_MS  = 16'd2500;
	localparam logic [2:0]  RST_SHAKE_COUNT  = 3'd3;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_PICKUP = 2'd1,
		EV_SHAKE  = 2'd2
	} spd_event_t;

	// classified sample passed from front to back
	typedef struct packed {
		logic        spike;
		logic [31:0] now_ms;
	} spd_entry_t;

	// back part status
	typedef struct packed {
		logic pop;
		logic fire_pickup;
		logic fire_shake;
	} spd_back_st_t;

endpackage

FILE: rtl/core/spd_front.sv
// ----------------------------------------------------------------------------
// spd_front
// Accepts samples, squares the axes and classifies each sample as spike or not.
// ----------------------------------------------------------------------------
module spd_front import spd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]       now_ms,
	input  logic [14:0]       rest_level,
	input  logic [14:0]       spike_margin,
	output logic              push,
	output spd_entry_t        push_entry,
	input  logic              q_full
);

	logic signed [31:0] prod_x, prod_y, prod_z;
	logic [30:0]        sq_x_s1, sq_y_s1, sq_z_s1;
	logic [31:0]        now_s1;
	logic               valid_s1;
	logic               advance;
	logic [15:0]        hi;
	logic [14:0]        lo;
	logic [31:0]        hi_sq_q;
	logic [29:0]        lo_sq_q;
	logic               lo_en_q;
	logic [31:0]        mag_sq;

	assign prod_x  = 32'(accel_x) * 32'(accel_x);
	assign prod_y  = 32'(accel_y) * 32'(accel_y);
	assign prod_z  = 32'(accel_z) * 32'(accel_z);
	assign advance = !valid_s1 || !q_full;
	assign in_ready = advance;

	// squared bounds are registered and follow the config registers in the next cycle
	assign hi = {1'b0, rest_level} + {1'b0, spike_margin};
	assign lo = rest_level - spike_margin;

	always_ff @(posedge clk) begin
		hi_sq_q <= {16'd0, hi} * {16'd0, hi};
		lo_sq_q <= {15'd0, lo} * {15'd0, lo};
		lo_en_q <= rest_level > spike_margin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			sq_x_s1 <= prod_x[30:0];
			sq_y_s1 <= prod_y[30:0];
			sq_z_s1 <= prod_z[30:0];
			now_s1  <= now_ms;
		end
	end

	assign mag_sq = {1'b0, sq_x_s1} + {1'b0, sq_y_s1} + {1'b0, sq_z_s1};

	assign push              = valid_s1 && !q_full;
	assign push_entry.now_ms = now_s1;
	assign push_entry.spike  = (mag_sq > hi_sq_q) ||
		(lo_en_q && (mag_sq < {2'b00, lo_sq_q}));

endmodule

FILE: rtl/core/spd_queue.sv
// ----------------------------------------------------------------------------
// spd_queue
// Short fifo between the classifying front and the event back part.
// ----------------------------------------------------------------------------
module spd_queue import spd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  spd_entry_t push_entry,
	input  logic       pop,
	output spd_entry_t head,
	output logic       empty,
	output logic       full
);

	spd_entry_t            mem_q [SPD_QUEUE_DEPTH];
	logic [SPD_QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [SPD_QPTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (SPD_QPTR_W+1)'(SPD_QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/spd_back.sv
// ----------------------------------------------------------------------------
// spd_back
// Cooldown, spike ring and event decision; holds the result register.
// ----------------------------------------------------------------------------
module spd_back import spd_pkg::*; #(
	parameter int SLOTS = SPD_SLOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  spd_entry_t   head,
	input  logic         q_empty,
	input  logic [15:0]  window_ms,
	input  logic [15:0]  cooldown_ms,
	input  logic [2:0]   shake_count,
	output spd_back_st_t st,
	output logic         out_valid,
	input  logic         out_ready,
	output spd_event_t   event_res
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KW = (CW > 3) ? CW : 3;

	logic [31:0]   ring_q [SLOTS];
	logic [SW-1:0] wslot_q;
	logic [SW-1:0] wslot_nxt;
	logic [31:0]   last_q;
	logic          out_valid_q;
	spd_event_t    event_q;

	logic          pop;
	logic          cool;
	logic          active;
	logic [31:0]   since_event;
	logic [31:0]   slot_t   [SLOTS];
	logic [31:0]   slot_age [SLOTS];
	logic [SLOTS-1:0] hit;
	logic [CW-1:0] cnt;
	logic          is_shake;
	logic          is_pickup;

	assign pop         = !q_empty && (!out_valid_q || out_ready);
	assign since_event = head.now_ms - last_q;
	assign cool        = since_event < {16'd0, cooldown_ms};
	assign active      = pop && !cool && head.spike;

	// ring as it reads after this spike is written
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_t[i]   = (wslot_q == SW'(i)) ? head.now_ms : ring_q[i];
			slot_age[i] = head.now_ms - slot_t[i];
			hit[i]      = (slot_t[i] != '0) && (slot_age[i] < {16'd0, window_ms});
		end
	end

	assign cnt       = CW'($countones(hit));
	assign is_shake  = active && (KW'(cnt) >= KW'(shake_count));
	assign is_pickup = active && !is_shake && (cnt == CW'(1));
	assign wslot_nxt = (wslot_q == SW'(SLOTS - 1)) ? '0 : wslot_q + 1'b1;

	assign st.pop         = pop;
	assign st.fire_pickup = is_pickup;
	assign st.fire_shake  = is_shake;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ring_q[i] <= '0;
			end
			wslot_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			event_q     <= EV_NONE;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				event_q     <= is_shake ? EV_SHAKE : (is_pickup ? EV_PICKUP : EV_NONE);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (is_shake) begin
				for (int i = 0; i < SLOTS; i++) begin
					ring_q[i] <= '0;
				end
				wslot_q <= '0;
			end else if (active) begin
				ring_q[wslot_q] <= head.now_ms;
				wslot_q         <= wslot_nxt;
			end
			if (is_shake || is_pickup) begin
				last_q <= head.now_ms;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

endmodule

FILE: rtl/core/shake_pickup_detector_unit.sv
// ----------------------------------------------------------------------------
// shake_pickup_detector_unit
// Three-axis shake and pickup detector with a streaming sample interface.
// ----------------------------------------------------------------------------
// Takes one accelerometer sample per clock while s_axis_tready is high and
// returns one event code per sample, in order: 0 none, 1 pickup, 2 shake. A
// sample is squared in the first stage, compared against the squared rest
// bounds in the second and queued; the event part then applies cooldown,
// updates the spike ring and loads the result register. Sustained rate is
// one item per cycle while the output side does not stall, set by the ring
// compare in the event part; a four-entry queue between the two parts
// absorbs output stalls. Configuration writes are accepted every cycle and
// should be made while the block is idle.
module shake_pickup_detector_unit import spd_pkg::*; #(
	parameter int SLOTS = SPD_SLOTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
	input  logic [79:0]               s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// event_res[1:0], zero fill [7:2]
	output logic [7:0]                m_axis_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [SPD_CFG_IDX_W-1:0]  cfg_index,
	input  logic [SPD_CFG_DATA_W-1:0] cfg_data
);

	logic [14:0]  rest_level_q;
	logic [14:0]  spike_margin_q;
	logic [15:0]  window_ms_q;
	logic [15:0]  cooldown_ms_q;
	logic [2:0]   shake_count_q;

	logic         q_push;
	spd_entry_t   q_push_entry;
	spd_entry_t   q_head;
	logic         q_empty;
	logic         q_full;
	spd_back_st_t bk_st;
	spd_event_t   event_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_level_q   <= RST_REST_LEVEL;
			spike_margin_q <= RST_SPIKE_MARGIN;
			window_ms_q    <= RST_WINDOW_MS;
			cooldown_ms_q  <= RST_COOLDOWN_MS;
			shake_count_q  <= RST_SHAKE_COUNT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_REST_LEVEL:   rest_level_q   <= cfg_data[14:0];
				CFG_SPIKE_MARGIN: spike_margin_q <= cfg_data[14:0];
				CFG_WINDOW_MS:    window_ms_q    <= cfg_data;
				CFG_COOLDOWN_MS:  cooldown_ms_q  <= cfg_data;
				CFG_SHAKE_COUNT:  shake_count_q  <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	spd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.accel_x      (s_axis_tdata[15:0]),
		.accel_y      (s_axis_tdata[31:16]),
		.accel_z      (s_axis_tdata[47:32]),
		.now_ms       (s_axis_tdata[79:48]),
		.rest_level   (rest_level_q),
		.spike_margin (spike_margin_q),
		.push         (q_push),
		.push_entry   (q_push_entry),
		.q_full       (q_full)
	);

	spd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (bk_st.pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	spd_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.window_ms   (window_ms_q),
		.cooldown_ms (cooldown_ms_q),
		.shake_count (shake_count_q),
		.st          (bk_st),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.event_res   (event_res)
	);

	assign m_axis_tdata = {6'd0, event_res};

	// the event part never reads an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		bk_st.pop |-> !q_empty)
		else $error("event part popped an empty queue");

	// an event only comes from a popped spike
	a_event_from_spike: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_st.fire_shake || bk_st.fire_pickup) |-> (bk_st.pop && q_head.spike))
		else $error("event fired without a popped spike");

	// a fired shake shows up as the next result
	a_event_reported: assert property (@(posedge clk) disable iff (!arst_n)
		bk_st.fire_shake |=> (m_axis_tvalid && m_axis_tdata[1:0] == EV_SHAKE))
		else $error("shake not reported");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
		else $error("illegal event code");

endmodule

FILE: verif/tb_shake_pickup_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shake_pickup_detector_unit
// Self-checking bench for the shake and pickup detector.
// ----------------------------------------------------------------------------
// Drives accelerometer samples with millisecond timestamps into the stream
// input and predicts every event code with a cycle-free model of the
// cooldown, squared-magnitude spike test and timestamp ring. Results are
// compared in order against the prediction. A directed opening covers the
// magnitude bounds, time zero, wrapped time and the odd shake counts; then
// a series of register settings runs gesture-like random traffic with random
// input gaps, output stalls, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_shake_pickup_detector_unit;
	import spd_pkg::*;

	localparam int NUM_SLOTS = SPD_SLOTS;

	typedef enum int {
		MOT_QUIET,
		MOT_HIGH,
		MOT_LOW,
		MOT_NOISE
	} motion_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	// accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
	logic [79:0]               s_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	// event_res[1:0], zero fill [7:2]
	logic [7:0]                m_axis_tdata;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [SPD_CFG_IDX_W-1:0]  cfg_index;
	logic [SPD_CFG_DATA_W-1:0] cfg_data;

	// detector model: registers and state
	logic [14:0] cfg_rest;
	logic [14:0] cfg_thr;
	logic [15:0] cfg_window;
	logic [15:0] cfg_cool;
	logic [2:0]  cfg_count;
	logic [31:0] ring_times [NUM_SLOTS];
	int          ring_wr;
	logic [31:0] last_evt_ms;

	spd_event_t  exp_events [$];
	int          err_count    = 0;
	int          items_sent   = 0;
	logic [31:0] clock_ms     = '0;

	// sender and receiver idling controls
	int          burst_left   = 0;
	bit          tx_gaps      = 1'b1;
	int          tx_gap_max   = 4;
	int          rx_stall_pct = 30;
	int          hold_req_len = 0;
	int          hold_req_seq = 0;

	shake_pickup_detector_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic spd_event_t predict_event(input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az, input logic [31:0] now);
		longint          sx, sy, sz;
		longint unsigned mag2, upper, lower;
		logic [31:0]     since, age;
		int              hits;
		bit              spike;
		since = now - last_evt_ms;
		if (since < {16'd0, cfg_cool})
			return EV_NONE;
		sx = longint'($signed(ax));
		sy = longint'($signed(ay));
		sz = longint'($signed(az));
		mag2 = sx * sx + sy * sy + sz * sz;
		upper = longint'(cfg_rest) + longint'(cfg_thr);
		spike = mag2 > upper * upper;
		if (cfg_rest > cfg_thr) begin
			lower = longint'(cfg_rest) - longint'(cfg_thr);
			if (mag2 < lower * lower)
				spike = 1'b1;
		end
		if (!spike)
			return EV_NONE;
		ring_times[ring_wr] = now;
		ring_wr = (ring_wr + 1 >= NUM_SLOTS) ? 0 : ring_wr + 1;
		hits = 0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			age = now - ring_times[i];
			// zero timestamp marks an empty slot
			if (ring_times[i] != 32'd0 && age < {16'd0, cfg_window})
				hits++;
		end
		if (hits >= int'(cfg_count)) begin
			last_evt_ms = now;
			for (int i = 0; i < NUM_SLOTS; i++)
				ring_times[i] = '0;
			ring_wr = 0;
			return EV_SHAKE;
		end
		if (hits == 1) begin
			last_evt_ms = now;
			return EV_PICKUP;
		end
		return EV_NONE;
	endfunction

	// magnitude placed on one axis, small jitter on the other two
	function automatic void shape_sample(input motion_t kind, output logic [15:0] ax,
			output logic [15:0] ay, output logic [15:0] az);
		int          lo, hi, mag, axis;
		logic [15:0] v;
		hi = int'(cfg_rest) + int'(cfg_thr);
		lo = (cfg_rest > cfg_thr) ? int'(cfg_rest) - int'(cfg_thr) : 0;
		if (kind == MOT_HIGH && hi >= 32767)
			kind = MOT_NOISE;
		if (kind == MOT_LOW && lo == 0)
			kind = MOT_QUIET;
		if (kind == MOT_NOISE) begin
			ax = 16'($urandom_range(0, 65535));
			ay = 16'($urandom_range(0, 65535));
			az = 16'($urandom_range(0, 65535));
			return;
		end
		case (kind)
			MOT_HIGH: mag = $urandom_range(hi + 1, 32767);
			MOT_LOW:  mag = $urandom_range(0, lo - 1);
			default:  mag = $urandom_range(lo, (hi > 32767) ? 32767 : hi);
		endcase
		v = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
		if (kind == MOT_HIGH && mag == 32767 && $urandom_range(0, 3) == 0)
			v = 16'h8000;
		ax = 16'($urandom_range(0, 6) - 3);
		ay = 16'($urandom_range(0, 6) - 3);
		az = 16'($urandom_range(0, 6) - 3);
		axis = $urandom_range(0, 2);
		if (axis == 0)
			ax = v;
		else if (axis == 1)
			ay = v;
		else
			az = v;
	endfunction

	// called and returns at a falling edge
	task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az, input logic [31:0] now);
		int gap;
		if (tx_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, tx_gap_max);
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {now, az, ay, ax};
		do @(posedge clk); while (!s_axis_tready);
		exp_events.push_back(predict_event(ax, ay, az, now));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_at(input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az, input logic [31:0] now);
		clock_ms = now;
		send_sample(ax, ay, az, now);
	endtask

	task automatic send_motion(input motion_t kind);
		logic [15:0] ax, ay, az;
		shape_sample(kind, ax, ay, az);
		send_sample(ax, ay, az, clock_ms);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (exp_events.size() != 0)
			@(negedge clk);
		// let the pipeline settle before touching registers
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [SPD_CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_REST_LEVEL:   cfg_rest   = data[14:0];
			CFG_SPIKE_MARGIN: cfg_thr    = data[14:0];
			CFG_WINDOW_MS:    cfg_window = data;
			CFG_COOLDOWN_MS:  cfg_cool   = data;
			CFG_SHAKE_COUNT:  cfg_count  = data[2:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [14:0] rest, input logic [14:0] thr,
			input logic [15:0] win, input logic [15:0] cool, input logic [2:0] cnt);
		wait_idle();
		write_reg(CFG_REST_LEVEL, {1'b0, rest});
		write_reg(CFG_SPIKE_MARGIN, {1'b0, thr});
		write_reg(CFG_WINDOW_MS, win);
		write_reg(CFG_COOLDOWN_MS, cool);
		write_reg(CFG_SHAKE_COUNT, {13'd0, cnt});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int n_items);
		int stop_at, pick, k, step_max;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// gesture: leave cooldown, then a cluster of spikes
				clock_ms += cfg_cool + $urandom_range(0, 300);
				k = $urandom_range(1, 6);
				step_max = (cfg_window > 8) ? int'(cfg_window) / 4 : 2;
				for (int j = 0; j < k; j++) begin
					repeat ($urandom_range(0, 2)) begin
						clock_ms += $urandom_range(0, 3);
						send_motion(MOT_QUIET);
					end
					send_motion(($urandom_range(0, 3) == 0) ? MOT_LOW : MOT_HIGH);
					clock_ms += $urandom_range(1, step_max);
				end
			end else if (pick < 70) begin
				repeat ($urandom_range(3, 12)) begin
					clock_ms += $urandom_range(1, 40);
					send_motion(MOT_QUIET);
				end
			end else if (pick < 85) begin
				// noise with time jumps either way
				case ($urandom_range(0, 2))
					0:       clock_ms += $urandom_range(0, 5000);
					1:       clock_ms -= $urandom_range(0, 3000);
					default: clock_ms = $urandom();
				endcase
				send_motion(MOT_NOISE);
			end else begin
				// broken gesture: spikes spread wider than the window
				repeat ($urandom_range(2, 4)) begin
					clock_ms += cfg_window + $urandom_range(1, 400);
					send_motion(MOT_HIGH);
				end
			end
		end
	endtask

	task automatic run_phase(input logic [14:0] rest, input logic [14:0] thr,
			input logic [15:0] win, input logic [15:0] cool, input logic [2:0] cnt,
			input int n_items);
		apply_config(rest, thr, win, cool, cnt);
		tx_gaps      = ($urandom_range(0, 3) != 0);
		tx_gap_max   = $urandom_range(1, 8);
		rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
		run_random(n_items);
	endtask

	task automatic test_directed();
		// reset settings: start of time, bounds of the magnitude test
		send_at(16'sd32767, 16'sd0, 16'sd0, 32'd5);
		send_at(16'sd0, 16'sd0, 16'sd0, 32'd2499);
		send_at(-16'sd32768, -16'sd32768, -16'sd32768, 32'd2500);
		send_at(16'sd5769, 16'sd0, 16'sd0, 32'd2600);
		send_at(16'sd4096, 16'sd0, 16'sd0, 32'd5000);
		send_at(16'sd5768, 16'sd0, 16'sd0, 32'd5001);
		send_at(16'sd0, -16'sd5769, 16'sd0, 32'd5002);
		send_at(16'sd0, 16'sd0, 16'sd2424, 32'd7600);
		send_at(16'sd0, 16'sd0, 16'sd2423, 32'd7601);
		// no cooldown: spike at time zero, pickup, shake, wrapped time
		apply_config(15'd4096, 15'd1672, 16'd1000, 16'd0, 3'd3);
		send_at(16'sd32767, 16'sd32767, 16'sd32767, 32'd0);
		send_at(16'sd0, 16'sd0, 16'sd0, 32'd100);
		send_at(-16'sd32768, 16'sd0, 16'sd0, 32'd200);
		send_at(16'sd0, 16'sd32767, 16'sd0, 32'd300);
		send_at(16'sd4096, 16'sd1, -16'sd1, 32'd400);
		send_at(16'sd6000, 16'sd0, 16'sd0, 32'hFFFF_FF00);
		send_at(16'sd6000, 16'sd0, 16'sd0, 32'h0000_0010);
		send_at(16'sd0, 16'sd0, 16'sd6000, 32'h0000_0020);
		// threshold above rest, zero window
		apply_config(15'd100, 15'd200, 16'd0, 16'd0, 3'd1);
		send_at(16'sd0, 16'sd0, 16'sd0, 32'd1000);
		send_at(16'sd301, 16'sd0, 16'sd0, 32'd1001);
		// shake count zero: every spike is a shake
		apply_config(15'd100, 15'd200, 16'd500, 16'd0, 3'd0);
		send_at(16'sd400, 16'sd0, 16'sd0, 32'd2000);
		send_at(16'sd0, 16'sd0, 16'sd0, 32'd2001);
		// shake count above the ring size: pickups only
		apply_config(15'd100, 15'd50, 16'd500, 16'd0, 3'd6);
		send_at(16'sd0, 16'sd0, 16'sd10, 32'd3000);
		send_at(16'sd0, 16'sd0, 16'sd10, 32'd3001);
		send_at(16'sd200, 16'sd0, 16'sd0, 32'd3002);
		send_at(16'sd200, 16'sd0, 16'sd0, 32'd3003);
		send_at(16'sd200, 16'sd0, 16'sd0, 32'd3004);
	endtask

	task automatic test_config_sweep();
		logic [14:0] rest, thr;
		logic [15:0] win, cool;
		logic [2:0]  cnt;
		run_phase(15'd4096, 15'd1672, 16'd1000, 16'd2500, 3'd3, 90);
		run_phase(15'd4096, 15'd1672, 16'd1000, 16'd200, 3'd3, 90);
		run_phase(15'd0, 15'd0, 16'd65535, 16'd0, 3'd2, 90);
		run_phase(15'd32767, 15'd32767, 16'd65535, 16'd65535, 3'd5, 60);
		run_phase(15'd32767, 15'd0, 16'd1, 16'd0, 3'd1, 90);
		run_phase(15'd1000, 15'd32767, 16'd0, 16'd100, 3'd4, 80);
		run_phase(15'd2000, 15'd500, 16'd3000, 16'd50, 3'd1, 90);
		run_phase(15'd3000, 15'd800, 16'd2000, 16'd0, 3'd0, 90);
		run_phase(15'd4096, 15'd1000, 16'd1500, 16'd300, 3'd6, 90);
		run_phase(15'd4096, 15'd1000, 16'd1500, 16'd300, 3'd7, 90);
		run_phase(15'd8000, 15'd4000, 16'd65535, 16'd65535, 3'd5, 90);
		for (int p = 0; p < 4; p++) begin
			win  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 4000))
				: 16'($urandom_range(0, 65535));
			cool = 16'($urandom_range(0, win));
			rest = (p == 3) ? 15'($urandom_range(0, 32767)) : 15'($urandom_range(200, 12000));
			thr  = (p == 3) ? 15'($urandom_range(0, 32767)) : 15'($urandom_range(0, rest));
			cnt  = 3'($urandom_range(0, 7));
			run_phase(rest, thr, win, cool, cnt, 90);
		end
	endtask

	task automatic test_output_backpressure();
		apply_config(15'd4096, 15'd1672, 16'd800, 16'd100, 3'd3);
		tx_gaps      = 1'b0;
		rx_stall_pct = 0;
		// long output hold-off while the sender keeps pushing
		hold_req_len = 300;
		hold_req_seq++;
		run_random(150);
	endtask

	task automatic test_drain_pause();
		tx_gaps      = 1'b1;
		tx_gap_max   = 6;
		rx_stall_pct = 40;
		run_random(60);
		wait_idle();
		run_random(60);
	endtask

	// output side ready pattern
	initial begin : rx_side
		int hold_left, stall_left, seen_seq;
		hold_left     = 0;
		stall_left    = 0;
		seen_seq      = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req_seq != seen_seq) begin
				seen_seq  = hold_req_seq;
				hold_left = hold_req_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				stall_left = $urandom_range(0, 5);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		spd_event_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (exp_events.size() == 0) begin
					$error("event_res: no item expected, actual %0d", m_axis_tdata[1:0]);
					err_count++;
				end else begin
					want = exp_events.pop_front();
					if (m_axis_tdata[1:0] !== want) begin
						$error("event_res: expected %0d, actual %0d", want, m_axis_tdata[1:0]);
						err_count++;
					end
				end
			end
		end
	end

	initial begin
		int waited;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_REST_LEVEL;
		cfg_data      = '0;
		arst_n        = 1'b0;
		cfg_rest      = RST_REST_LEVEL;
		cfg_thr       = RST_SPIKE_MARGIN;
		cfg_window    = RST_WINDOW_MS;
		cfg_cool      = RST_COOLDOWN_MS;
		cfg_count     = RST_SHAKE_COUNT;
		for (int i = 0; i < NUM_SLOTS; i++)
			ring_times[i] = '0;
		ring_wr     = 0;
		last_evt_ms = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_config_sweep();
		test_output_backpressure();
		test_drain_pause();

		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (exp_events.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		if (exp_events.size() != 0) begin
			$error("event_res: %0d expected items never arrived", exp_events.size());
			err_count++;
		end
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
